FILE: src/scfla_pkg.sv
// Package for the size-class free-list allocator: sizes, item structs,
// status codes and sequencer states. No dependencies.
package scfla_pkg;

    localparam int HEAP_BYTES   = 1048576;
    localparam int NUM_CLASSES  = 64;
    localparam int HEADER_BYTES = 16;

    localparam int UNIT_SHIFT = 8;
    localparam int UNIT_COUNT = HEAP_BYTES >> UNIT_SHIFT;
    localparam int UNIT_W     = $clog2(UNIT_COUNT);
    localparam int LINK_W     = UNIT_W + 1;
    localparam int CLASS_AW   = $clog2(NUM_CLASSES);
    localparam int POS_W      = $clog2(HEAP_BYTES) + 1;
    localparam int SUM_W      = POS_W + 1;

    // fixed field widths
    localparam int REQ_W      = 16;
    localparam int ADDR_W     = 20;
    localparam int CLASS_W    = 6;
    localparam int CHUNK_W    = 17;
    localparam int SLAB_W     = 17;
    localparam int LIMIT_W    = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [LINK_W-1:0]    EMPTY_MARK = LINK_W'(UNIT_COUNT);
    localparam logic [CFG_IDX_W-1:0] CFG_SLAB   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(1);
    localparam logic                 ACT_ALLOC  = 1'b0;
    localparam logic                 ACT_FREE   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_HEAD,
        S_R_END,
        S_FILL,
        S_A_LINK,
        S_F_TAG,
        S_F_HEAD
    } t_state;

    typedef struct packed {
        logic              action;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] release_address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  payload_address;
        t_status            status;
        logic [CLASS_W-1:0] size_class;
    } t_out_item;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [CHUNK_W-1:0] chunk;
        logic               slab_refill;   // refill from a slab when list is empty
        logic               bad;           // class beyond the table
    } t_class_info;

    function automatic logic [ADDR_W-1:0] unit_to_payload(input logic [UNIT_W-1:0] unit);
        unit_to_payload = ADDR_W'({unit, {UNIT_SHIFT{1'b0}}}) + ADDR_W'(HEADER_BYTES);
    endfunction

endpackage

FILE: src/scfla_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module scfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

FILE: src/scfla_class_dec.sv
// Size-class decode: header add, class number and chunk size of a request.
// Depends on scfla_pkg.
module scfla_class_dec (
    input  logic [scfla_pkg::REQ_W-1:0] i_request_bytes,
    output scfla_pkg::t_class_info      o_info
);
    import scfla_pkg::*;

    logic [REQ_W:0]   sum;
    logic [REQ_W+1:0] round;
    logic [4:0]       q_small;
    logic [5:0]       q_large;

    always_comb begin
        sum     = (REQ_W+1)'(i_request_bytes) + (REQ_W+1)'(HEADER_BYTES);
        round   = (REQ_W+2)'(sum) + (REQ_W+2)'(255);
        q_small = round[12:8];
        round   = (REQ_W+2)'(sum) + (REQ_W+2)'(4095);
        q_large = round[17:12];
        if (sum < (REQ_W+1)'(4096)) begin
            o_info.cls   = CLASS_W'(q_small);
            o_info.chunk = CHUNK_W'({q_small, 8'h00});
        end else begin
            o_info.cls   = CLASS_W'(q_large) + CLASS_W'(16);
            o_info.chunk = CHUNK_W'({q_large, 12'h000});
        end
        o_info.slab_refill = (sum <= (REQ_W+1)'(4096));
        o_info.bad         = (int'(o_info.cls) >= NUM_CLASSES);
    end

endmodule

FILE: src/size_class_free_list_allocator_core.sv
// Top level of the size-class free-list allocator: sequencer, fill adder,
// class-head valid bits. Depends on scfla_pkg, scfla_ram, scfla_class_dec.
//
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+---------------------------
//  request   | start, busy, i_item                        | accepted: start && !busy
//  result    | o_done, o_result                           | one-cycle strobe, no stall
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data | valid && ready (ready = 1)
//
// Free passes through S_F_TAG and S_F_HEAD; allocate from a non-empty list through
// S_A_HEAD and S_A_LINK. Allocate of a large chunk with an empty list ends in S_A_HEAD.
// Slab refill: S_R_END, then S_FILL carves up to 511 chunks, one push per cycle
// through the fill adder/compare; list reads go through the registered RAM ports.
// The next item may be started in the cycle the result strobe is high.
// Reset (synchronous, active low) empties all lists through per-class valid bits.
module size_class_free_list_allocator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  scfla_pkg::t_in_item              i_item,
    output logic                             o_done,
    output scfla_pkg::t_out_item             o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [scfla_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scfla_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import scfla_pkg::*;

    t_state              r_state, n_state;
    logic                r_done, n_done;
    t_out_item           r_res, n_res;
    logic [NUM_CLASSES-1:0] r_head_vld, n_head_vld;
    logic                r_hq_vld;
    logic [POS_W-1:0]    r_bump, n_bump;
    logic [SLAB_W-1:0]   r_slab;
    logic [LIMIT_W-1:0]  r_heap_limit;

    logic [CLASS_W-1:0]  r_cls, n_cls;
    logic [CHUNK_W-1:0]  r_chunk, n_chunk;
    logic                r_small, n_small;
    logic                r_bad, n_bad;
    logic [UNIT_W-1:0]   r_unit, n_unit;
    logic [POS_W-1:0]    r_addr, n_addr;
    logic [POS_W-1:0]    r_end, n_end;
    logic [POS_W-1:0]    r_room, n_room;
    logic [LINK_W-1:0]   r_fill_head, n_fill_head;
    logic                r_fill_any, n_fill_any;

    logic [CLASS_AW-1:0] heads_addr;
    logic                heads_we;
    logic [LINK_W-1:0]   heads_wd, heads_q;
    logic [UNIT_W-1:0]   links_addr;
    logic                links_we;
    logic [LINK_W-1:0]   links_wd, links_q;
    logic [UNIT_W-1:0]   tags_addr;
    logic                tags_we;
    logic [CLASS_W-1:0]  tags_wd, tags_q;

    t_class_info         ci;
    logic [POS_W-1:0]    limit;
    logic [LINK_W-1:0]   head;
    logic [SUM_W-1:0]    fill_next;
    logic [POS_W-1:0]    span;
    logic [ADDR_W-1:0]   start_addr;

    scfla_class_dec u_dec (
        .i_request_bytes (i_item.request_bytes),
        .o_info          (ci)
    );

    scfla_ram #(.WIDTH(LINK_W), .DEPTH(NUM_CLASSES)) u_heads (
        .i_clk (i_clk), .i_addr (heads_addr), .i_we (heads_we),
        .i_wdata (heads_wd), .o_rdata (heads_q)
    );

    scfla_ram #(.WIDTH(LINK_W), .DEPTH(UNIT_COUNT)) u_links (
        .i_clk (i_clk), .i_addr (links_addr), .i_we (links_we),
        .i_wdata (links_wd), .o_rdata (links_q)
    );

    scfla_ram #(.WIDTH(CLASS_W), .DEPTH(UNIT_COUNT)) u_tags (
        .i_clk (i_clk), .i_addr (tags_addr), .i_we (tags_we),
        .i_wdata (tags_wd), .o_rdata (tags_q)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_res;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_done      = 1'b0;
        n_res       = r_res;
        n_head_vld  = r_head_vld;
        n_bump      = r_bump;
        n_cls       = r_cls;
        n_chunk     = r_chunk;
        n_small     = r_small;
        n_bad       = r_bad;
        n_unit      = r_unit;
        n_addr      = r_addr;
        n_end       = r_end;
        n_room      = r_room;
        n_fill_head = r_fill_head;
        n_fill_any  = r_fill_any;

        heads_addr = CLASS_AW'(r_cls);
        heads_we   = 1'b0;
        heads_wd   = links_q;
        links_addr = r_unit;
        links_we   = 1'b0;
        links_wd   = EMPTY_MARK;
        tags_addr  = r_unit;
        tags_we    = 1'b0;
        tags_wd    = r_cls;

        limit = (32'(r_heap_limit) > 32'(HEAP_BYTES)) ? POS_W'(HEAP_BYTES)
                                                       : POS_W'(r_heap_limit);
        head       = r_hq_vld ? heads_q : EMPTY_MARK;
        fill_next  = SUM_W'(r_addr) + SUM_W'(r_chunk);
        span       = (POS_W'(r_slab) < r_room) ? POS_W'(r_slab) : r_room;
        start_addr = i_item.release_address - ADDR_W'(HEADER_BYTES);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.action == ACT_ALLOC) begin
                        n_cls      = ci.cls;
                        n_chunk    = ci.chunk;
                        n_small    = ci.slab_refill;
                        n_bad      = ci.bad;
                        heads_addr = CLASS_AW'(ci.cls);
                        n_state    = S_A_HEAD;
                    end else begin
                        n_unit    = start_addr[UNIT_SHIFT +: UNIT_W];
                        tags_addr = start_addr[UNIT_SHIFT +: UNIT_W];
                        n_bad     = (i_item.release_address < ADDR_W'(HEADER_BYTES))
                                 || (start_addr[UNIT_SHIFT-1:0] != '0)
                                 || (POS_W'(start_addr) >= r_bump);
                        n_state   = S_F_TAG;
                    end
                end
            end
            S_A_HEAD: begin
                if (r_bad) begin
                    n_done  = 1'b1;
                    n_res   = '{payload_address: '0, status: ST_OOM, size_class: r_cls};
                    n_state = S_IDLE;
                end else if (!head[UNIT_W]) begin
                    n_unit     = head[UNIT_W-1:0];
                    links_addr = head[UNIT_W-1:0];
                    n_state    = S_A_LINK;
                end else if (r_small) begin
                    n_room  = (r_bump < limit) ? (limit - r_bump) : '0;
                    n_state = S_R_END;
                end else if ((SUM_W'(r_bump) + SUM_W'(r_chunk)) > SUM_W'(limit)) begin
                    n_done  = 1'b1;
                    n_res   = '{payload_address: '0, status: ST_OOM, size_class: r_cls};
                    n_state = S_IDLE;
                end else begin
                    // large chunk carved straight from the bump pointer
                    tags_addr  = r_bump[UNIT_SHIFT +: UNIT_W];
                    tags_we    = 1'b1;
                    links_addr = r_bump[UNIT_SHIFT +: UNIT_W];
                    links_we   = 1'b1;
                    n_bump     = POS_W'(SUM_W'(r_bump) + SUM_W'(r_chunk));
                    n_done     = 1'b1;
                    n_res      = '{payload_address: unit_to_payload(
                                       r_bump[UNIT_SHIFT +: UNIT_W]),
                                   status: ST_OK, size_class: r_cls};
                    n_state    = S_IDLE;
                end
            end
            S_R_END: begin
                n_end       = r_bump + span;
                n_addr      = r_bump;
                n_fill_head = EMPTY_MARK;
                n_fill_any  = 1'b0;
                n_state     = S_FILL;
            end
            S_FILL: begin
                if (fill_next <= SUM_W'(r_end)) begin
                    tags_addr   = r_addr[UNIT_SHIFT +: UNIT_W];
                    tags_we     = 1'b1;
                    links_addr  = r_addr[UNIT_SHIFT +: UNIT_W];
                    links_we    = 1'b1;
                    links_wd    = r_fill_head;
                    n_fill_head = {1'b0, r_addr[UNIT_SHIFT +: UNIT_W]};
                    n_addr      = POS_W'(fill_next);
                    n_fill_any  = 1'b1;
                end else if (!r_fill_any) begin
                    n_done  = 1'b1;
                    n_res   = '{payload_address: '0, status: ST_OOM, size_class: r_cls};
                    n_state = S_IDLE;
                end else begin
                    // slab done: pop the last pushed chunk
                    n_bump     = r_addr;
                    n_unit     = r_fill_head[UNIT_W-1:0];
                    links_addr = r_fill_head[UNIT_W-1:0];
                    n_state    = S_A_LINK;
                end
            end
            S_A_LINK: begin
                heads_we   = 1'b1;
                heads_wd   = links_q;
                n_head_vld[CLASS_AW'(r_cls)] = 1'b1;
                links_we   = 1'b1;
                links_wd   = EMPTY_MARK;
                n_done     = 1'b1;
                n_res      = '{payload_address: unit_to_payload(r_unit),
                               status: ST_OK, size_class: r_cls};
                n_state    = S_IDLE;
            end
            S_F_TAG: begin
                if (r_bad || (tags_q == '0) || (int'(tags_q) >= NUM_CLASSES)) begin
                    n_done  = 1'b1;
                    n_res   = '{payload_address: '0, status: ST_BAD_FREE, size_class: '0};
                    n_state = S_IDLE;
                end else begin
                    n_cls      = tags_q;
                    heads_addr = CLASS_AW'(tags_q);
                    n_state    = S_F_HEAD;
                end
            end
            S_F_HEAD: begin
                links_we   = 1'b1;
                links_wd   = head;
                heads_we   = 1'b1;
                heads_wd   = {1'b0, r_unit};
                n_head_vld[CLASS_AW'(r_cls)] = 1'b1;
                n_done     = 1'b1;
                n_res      = '{payload_address: '0, status: ST_OK, size_class: r_cls};
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_head_vld   <= '0;
            r_bump       <= '0;
            r_slab       <= SLAB_W'(65536);
            r_heap_limit <= LIMIT_W'(1048576);
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_head_vld <= n_head_vld;
            r_bump     <= n_bump;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLAB:  r_slab       <= i_cfg_data[SLAB_W-1:0];
                    CFG_LIMIT: r_heap_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res       <= n_res;
        r_hq_vld    <= r_head_vld[heads_addr];
        r_cls       <= n_cls;
        r_chunk     <= n_chunk;
        r_small     <= n_small;
        r_bad       <= n_bad;
        r_unit      <= n_unit;
        r_addr      <= n_addr;
        r_end       <= n_end;
        r_room      <= n_room;
        r_fill_head <= n_fill_head;
        r_fill_any  <= n_fill_any;
    end

endmodule

FILE: src/scfla_checker.sv
// Port-level checks for the allocator core, bound to the top level.
// Depends on scfla_pkg and size_class_free_list_allocator_core.
module scfla_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input scfla_pkg::t_out_item o_result
);
    import scfla_pkg::*;

    // an accepted item always makes the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // a result only ends a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a busy cycle before it");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_OK)) |-> (o_result.payload_address == '0))
        else $error("failed request returned a nonzero address");

    a_bad_free_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_BAD_FREE)) |-> (o_result.size_class == '0))
        else $error("bad free reported a nonzero class");

endmodule

bind size_class_free_list_allocator_core scfla_checker u_scfla_checker (.*);

FILE: tb/size_class_free_list_allocator_core_tb.sv
// Self-checking testbench for size_class_free_list_allocator_core: directed and random
// alloc/free items against an in-bench model of the class lists and bump pointer.
// Depends on scfla_pkg and the core RTL only.
module size_class_free_list_allocator_core_tb;
    import scfla_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef enum logic [1:0] {
        REL_LIVE,   // payload handed out earlier
        REL_ANY,    // any carved chunk, may already sit on a list
        REL_JUNK,   // random address, mostly bad frees
        REL_FIXED   // address given by the directed part
    } t_release_kind;

    typedef struct {
        logic              act;
        logic [REQ_W-1:0]  req;
        t_release_kind     kind;
        logic [ADDR_W-1:0] addr;
        bit                hold;   // wait until all results are back
    } t_job;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_item item_drv = '0;
    logic o_done;
    t_out_item o_result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    size_class_free_list_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (item_drv),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // allocator state as the block should hold it
    logic [LINK_W-1:0]  head_unit [NUM_CLASSES];
    logic [LINK_W-1:0]  link_unit [UNIT_COUNT];
    logic [CLASS_W-1:0] unit_tag [UNIT_COUNT];
    bit                 chunk_start [UNIT_COUNT];
    logic [POS_W-1:0]   bump_pos;
    logic [SLAB_W-1:0]  slab_cfg;
    logic [LIMIT_W-1:0] limit_cfg;

    t_job              request_q[$];
    t_out_item         pending_results[$];
    logic [ADDR_W-1:0] live_payloads[$];
    logic [UNIT_W-1:0] carved_units[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left = 0;
    bit          calm_mode = 1'b0;
    int unsigned corner_sizes[7] = '{0, 240, 241, 4079, 4080, 4081, 65535};

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic void carve_chunk(input int unsigned cls, input int unsigned unit,
                                        input logic [LINK_W-1:0] link);
        unit_tag[unit] = CLASS_W'(cls);
        link_unit[unit] = link;
        chunk_start[unit] = 1'b1;
        carved_units.push_back(UNIT_W'(unit));
    endfunction

    // Works out the result of one item and updates the lists and bump pointer.
    function automatic t_out_item apply_request(input t_in_item it);
        t_out_item r;
        int unsigned total, cls, chunk, room, span, count, lim, unit, start_b;
        r = '0;
        r.status = ST_OK;
        if (it.action == ACT_ALLOC) begin
            total = it.request_bytes + HEADER_BYTES;
            if (total < 4096) begin
                cls = (total + 255) / 256;
                chunk = cls * 256;
            end else begin
                cls = (total + 4095) / 4096 + 16;
                chunk = (cls - 16) * 4096;
            end
            r.size_class = CLASS_W'(cls);
            lim = (limit_cfg > HEAP_BYTES) ? HEAP_BYTES : limit_cfg;
            if (head_unit[cls] == EMPTY_MARK && total > 4096) begin
                // large chunk straight off the bump pointer
                if (bump_pos > lim || lim - bump_pos < chunk) begin
                    r.status = ST_OOM;
                end else begin
                    unit = bump_pos >> UNIT_SHIFT;
                    carve_chunk(cls, unit, EMPTY_MARK);
                    bump_pos = POS_W'(bump_pos + chunk);
                    r.payload_address = ADDR_W'((unit << UNIT_SHIFT) + HEADER_BYTES);
                end
            end else begin
                if (head_unit[cls] == EMPTY_MARK) begin
                    // slab refill, rising addresses so the highest pops first
                    room = (bump_pos < lim) ? lim - bump_pos : 0;
                    span = (slab_cfg < room) ? slab_cfg : room;
                    count = span / chunk;
                    for (int unsigned n = 0; n < count; n++) begin
                        unit = (bump_pos + n * chunk) >> UNIT_SHIFT;
                        carve_chunk(cls, unit, head_unit[cls]);
                        head_unit[cls] = LINK_W'(unit);
                    end
                    bump_pos = POS_W'(bump_pos + count * chunk);
                end
                if (head_unit[cls] == EMPTY_MARK) begin
                    r.status = ST_OOM;
                end else begin
                    unit = head_unit[cls];
                    head_unit[cls] = link_unit[unit];
                    link_unit[unit] = EMPTY_MARK;
                    r.payload_address = ADDR_W'((unit << UNIT_SHIFT) + HEADER_BYTES);
                end
            end
        end else begin
            r.status = ST_BAD_FREE;
            if (it.release_address >= HEADER_BYTES) begin
                start_b = it.release_address - HEADER_BYTES;
                unit = start_b >> UNIT_SHIFT;
                if ((start_b & 255) == 0 && start_b < bump_pos && unit < UNIT_COUNT
                    && unit_tag[unit] != 0) begin
                    cls = unit_tag[unit];
                    link_unit[unit] = head_unit[cls];
                    head_unit[cls] = LINK_W'(unit);
                    r.status = ST_OK;
                    r.size_class = CLASS_W'(cls);
                end
            end
        end
        return r;
    endfunction

    // feeds items from request_q, predicts each one as it is accepted
    always @(posedge i_clk) begin : drive_items
        t_job job;
        t_in_item nxt;
        t_out_item want;
        t_release_kind kind;
        logic [ADDR_W-1:0] a;
        int unsigned k;
        bit accepted;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = (start === 1'b1) && (busy === 1'b0);
            if (accepted) begin
                want = apply_request(item_drv);
                pending_results.push_back(want);
                if (item_drv.action == ACT_ALLOC && want.status == ST_OK)
                    live_payloads.push_back(want.payload_address);
                if (!calm_mode && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 7);
            end
            if (start && !accepted) begin
                // held until the block takes it
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (request_q.size() != 0
                         && !(request_q[0].hold && pending_results.size() != 0)) begin
                job = request_q.pop_front();
                nxt.action = job.act;
                nxt.request_bytes = job.req;
                nxt.release_address = job.addr;
                if (job.act == ACT_FREE) begin
                    kind = job.kind;
                    if (kind == REL_LIVE && live_payloads.size() == 0)
                        kind = REL_ANY;
                    if (kind == REL_ANY && carved_units.size() == 0)
                        kind = REL_JUNK;
                    case (kind)
                        REL_LIVE: begin
                            k = $urandom_range(0, live_payloads.size() - 1);
                            nxt.release_address = live_payloads[k];
                            live_payloads.delete(k);
                        end
                        REL_ANY: begin
                            k = $urandom_range(0, carved_units.size() - 1);
                            nxt.release_address = {carved_units[k], 8'(HEADER_BYTES)};
                        end
                        REL_JUNK: begin
                            case ($urandom_range(0, 2))
                                0: a = ADDR_W'($urandom_range(0, HEADER_BYTES - 1));
                                1: a = ADDR_W'($urandom());
                                default: begin
                                    if (bump_pos < HEAP_BYTES)
                                        a = {UNIT_W'($urandom_range(bump_pos >> UNIT_SHIFT,
                                                                    UNIT_COUNT - 1)),
                                             8'(HEADER_BYTES)};
                                    else
                                        a = ADDR_W'($urandom());
                                end
                            endcase
                            // never point at a unit inside a chunk: its tag was never written
                            if (a >= HEADER_BYTES && a[7:0] == 8'(HEADER_BYTES)
                                && (a - HEADER_BYTES) < bump_pos && !chunk_start[a[19:8]])
                                a[0] = 1'b1;
                            nxt.release_address = a;
                        end
                        default: ;
                    endcase
                end
                item_drv <= nxt;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // results are sampled mid-cycle, clear of the driving edge
    always @(negedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", o_result, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.payload_address !== want.payload_address)
                    report_mismatch("payload_address", o_result.payload_address,
                                    want.payload_address);
                if (o_result.status !== want.status)
                    report_mismatch("status", o_result.status, want.status);
                if (o_result.size_class !== want.size_class)
                    report_mismatch("size_class", o_result.size_class, want.size_class);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_job(input logic act, input int unsigned req,
                             input t_release_kind kind, input int unsigned addr,
                             input bit hold);
        t_job j;
        j.act = act;
        j.req = (act == ACT_ALLOC) ? REQ_W'(req) : REQ_W'($urandom());
        j.kind = kind;
        j.addr = (act == ACT_FREE && kind == REL_FIXED) ? ADDR_W'(addr) : ADDR_W'($urandom());
        j.hold = hold;
        request_q.push_back(j);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == CFG_SLAB)
            slab_cfg = data[SLAB_W-1:0];
        else
            limit_cfg = data[LIMIT_W-1:0];
    endtask

    // block idle: nothing queued, nothing outstanding
    task automatic settle();
        @(posedge i_clk);
        while (request_q.size() != 0 || start !== 1'b0 || pending_results.size() != 0
               || busy !== 1'b0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // room != 0 puts the limit that far above the current bump pointer
    task automatic run_phase(input int unsigned slab, input int unsigned limit,
                             input int unsigned room, input int n, input bit calm);
        int unsigned req, pick;
        settle();
        if (room != 0)
            limit = (bump_pos + room > HEAP_BYTES) ? HEAP_BYTES : bump_pos + room;
        write_reg(CFG_SLAB, CFG_DATA_W'(slab));
        write_reg(CFG_LIMIT, CFG_DATA_W'(limit));
        @(negedge i_clk);
        calm_mode = calm;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                case ($urandom_range(0, 19))
                    0, 1: req = corner_sizes[$urandom_range(0, 6)];
                    2: req = $urandom_range(0, 65535);
                    3, 4, 5, 6: req = $urandom_range(4081, 16368);
                    default: req = $urandom_range(0, 4080);
                endcase
                queue_job(ACT_ALLOC, req, REL_FIXED, 0, $urandom_range(0, 149) == 0);
            end else if (pick < 85) begin
                queue_job(ACT_FREE, 0, REL_LIVE, 0, 1'b0);
            end else if (pick < 90) begin
                queue_job(ACT_FREE, 0, REL_ANY, 0, 1'b0);
            end else begin
                queue_job(ACT_FREE, 0, REL_JUNK, 0, 1'b0);
            end
        end
    endtask

    initial begin : stimulus
        for (int c = 0; c < NUM_CLASSES; c++)
            head_unit[c] = EMPTY_MARK;
        for (int u = 0; u < UNIT_COUNT; u++) begin
            link_unit[u] = '0;
            unit_tag[u] = '0;
            chunk_start[u] = 1'b0;
        end
        bump_pos = '0;
        slab_cfg = SLAB_W'(65536);
        limit_cfg = LIMIT_W'(1048576);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest slab and limit: one slab fits, everything else runs dry
        run_phase(4096, 4096, 0, 0, 1'b0);
        queue_job(ACT_ALLOC, 0, REL_FIXED, 0, 1'b0);
        queue_job(ACT_ALLOC, 240, REL_FIXED, 0, 1'b0);
        queue_job(ACT_ALLOC, 241, REL_FIXED, 0, 1'b0);
        queue_job(ACT_ALLOC, 4080, REL_FIXED, 0, 1'b0);
        queue_job(ACT_ALLOC, 65535, REL_FIXED, 0, 1'b0);
        queue_job(ACT_FREE, 0, REL_FIXED, 0, 1'b0);
        queue_job(ACT_FREE, 0, REL_FIXED, 15, 1'b0);
        queue_job(ACT_FREE, 0, REL_FIXED, 17, 1'b0);
        queue_job(ACT_FREE, 0, REL_FIXED, 4096 + 16, 1'b0);
        queue_job(ACT_FREE, 0, REL_FIXED, 20'hFFFFF, 1'b0);
        queue_job(ACT_FREE, 0, REL_LIVE, 0, 1'b0);
        queue_job(ACT_FREE, 0, REL_FIXED, 16, 1'b0);   // free chunk already on its list
        queue_job(ACT_ALLOC, 0, REL_FIXED, 0, 1'b0);

        // full slab, limit above the heap size
        run_phase(65536, 21'h1FFFFF, 0, 0, 1'b0);
        queue_job(ACT_ALLOC, 65535, REL_FIXED, 0, 1'b0);
        queue_job(ACT_ALLOC, 4080, REL_FIXED, 0, 1'b0);   // header makes exactly 4096
        queue_job(ACT_ALLOC, 4079, REL_FIXED, 0, 1'b0);
        queue_job(ACT_ALLOC, 4081, REL_FIXED, 0, 1'b0);
        queue_job(ACT_ALLOC, 3825, REL_FIXED, 0, 1'b0);   // header rounds it up to a 4096-byte chunk
        queue_job(ACT_FREE, 0, REL_FIXED, 20'hFFF10, 1'b0);
        queue_job(ACT_FREE, 0, REL_LIVE, 0, 1'b1);
        queue_job(ACT_FREE, 0, REL_LIVE, 0, 1'b0);
        queue_job(ACT_FREE, 0, REL_ANY, 0, 1'b0);
        queue_job(ACT_ALLOC, 65535, REL_FIXED, 0, 1'b0);
        queue_job(ACT_ALLOC, 4081, REL_FIXED, 0, 1'b0);

        run_phase(4096, 0, $urandom_range(8192, 40000), 290, 1'b0);
        run_phase($urandom_range(4096, 65536), $urandom_range(4096, 1048576), 0, 290, 1'b0);
        run_phase($urandom_range(4096, 65536), 0, $urandom_range(8192, 200000), 290, 1'b0);
        run_phase(65536, 1048576, 0, 290, 1'b0);
        run_phase($urandom_range(4096, 65536), 21'h1FFFFF, 0, 290, 1'b0);
        run_phase($urandom_range(4096, 65536), 1048576, 0, 250, 1'b1);

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
